// ----- hw/rtl/eyxz_pkg.sv -----
// ----------------------------------------------------------------------------
// eyxz_pkg
// shared constants, types and helpers for the yxz euler world matrix
// ----------------------------------------------------------------------------
package eyxz_pkg;

    localparam int ANGLE_BITS     = 16;
    localparam int COEF_FRAC_BITS = 16;
    localparam int COEF_W         = COEF_FRAC_BITS + 2;
    localparam int CORDIC_ITERS   = 30;
    localparam int CW             = 34;
    localparam int PROD_W         = 2 * COEF_W;
    localparam int RND_SH         = 30 - COEF_FRAC_BITS;
    localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

    localparam logic signed [COEF_W-1:0] ONE_C  = COEF_W'(1) <<< COEF_FRAC_BITS;
    localparam logic signed [COEF_W-1:0] MONE_C = -(COEF_W'(1) <<< COEF_FRAC_BITS);

    typedef logic signed [COEF_W-1:0] coef_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 flip;
    } cordic_t;

    function automatic logic signed [CW-1:0] atan_entry(input logic [4:0] i);
        logic signed [CW-1:0] r;
        begin
            case (i)
                5'd0:  r = CW'(32'h20000000);
                5'd1:  r = CW'(32'h12E4051E);
                5'd2:  r = CW'(32'h09FB385B);
                5'd3:  r = CW'(32'h051111D4);
                5'd4:  r = CW'(32'h028B0D43);
                5'd5:  r = CW'(32'h0145D7E1);
                5'd6:  r = CW'(32'h00A2F61E);
                5'd7:  r = CW'(32'h00517C55);
                5'd8:  r = CW'(32'h0028BE53);
                5'd9:  r = CW'(32'h00145F2F);
                5'd10: r = CW'(32'h000A2F98);
                5'd11: r = CW'(32'h000517CC);
                5'd12: r = CW'(32'h00028BE6);
                5'd13: r = CW'(32'h000145F3);
                5'd14: r = CW'(32'h0000A2FA);
                5'd15: r = CW'(32'h0000517D);
                5'd16: r = CW'(32'h000028BE);
                5'd17: r = CW'(32'h0000145F);
                5'd18: r = CW'(32'h00000A30);
                5'd19: r = CW'(32'h00000518);
                5'd20: r = CW'(32'h0000028C);
                5'd21: r = CW'(32'h00000146);
                5'd22: r = CW'(32'h000000A3);
                5'd23: r = CW'(32'h00000051);
                5'd24: r = CW'(32'h00000029);
                5'd25: r = CW'(32'h00000014);
                5'd26: r = CW'(32'h0000000A);
                5'd27: r = CW'(32'h00000005);
                5'd28: r = CW'(32'h00000003);
                5'd29: r = CW'(32'h00000001);
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    function automatic coef_t clamp_c(input logic signed [CW-1:0] v);
        begin
            if (v > CW'(ONE_C))
                return ONE_C;
            else if (v < CW'(MONE_C))
                return MONE_C;
            else
                return COEF_W'(v);
        end
    endfunction

    // rounded q1.f product, floor shift
    function automatic logic signed [COEF_W:0] fx_mul(input coef_t a, input coef_t b);
        logic signed [PROD_W-1:0] p;
        begin
            p = PROD_W'(a) * PROD_W'(b) + (PROD_W'(1) <<< (COEF_FRAC_BITS - 1));
            return (COEF_W+1)'(p >>> COEF_FRAC_BITS);
        end
    endfunction

endpackage

// ----- hw/rtl/eyxz_cordic_stage.sv -----
// ----------------------------------------------------------------------------
// eyxz_cordic_stage
// one registered rotation-mode cordic micro-rotation for three angles
// ----------------------------------------------------------------------------
module eyxz_cordic_stage
    import eyxz_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [4:0]   iter,
    input  logic         in_valid,
    input  cordic_t      in_ang [3],
    output logic         out_valid,
    output cordic_t      out_ang [3]
);

    logic    valid_reg;
    cordic_t ang_reg  [3];
    cordic_t ang_next [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ang_next[k] = in_ang[k];
            if (in_ang[k].z >= 0)
            begin
                ang_next[k].x = in_ang[k].x - (in_ang[k].y >>> iter);
                ang_next[k].y = in_ang[k].y + (in_ang[k].x >>> iter);
                ang_next[k].z = in_ang[k].z - atan_entry(iter);
            end
            else
            begin
                ang_next[k].x = in_ang[k].x + (in_ang[k].y >>> iter);
                ang_next[k].y = in_ang[k].y - (in_ang[k].x >>> iter);
                ang_next[k].z = in_ang[k].z + atan_entry(iter);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        ang_reg <= ang_next;
    end

    assign out_valid = valid_reg;
    assign out_ang   = ang_reg;

endmodule

// ----- hw/rtl/eyxz_matrix.sv -----
// ----------------------------------------------------------------------------
// eyxz_matrix
// three-stage product and sum pipeline from sines and cosines to entries
// ----------------------------------------------------------------------------
module eyxz_matrix
    import eyxz_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  coef_t sy, cy, sp, cp, sr, cr,
    output logic  out_valid,
    output coef_t m [9]
);

    logic [2:0] valid_reg;
    // stage a: first-level products
    coef_t sysp_reg, cysp_reg, sy_a_reg, cy_a_reg, sr_a_reg, cr_a_reg;
    logic signed [COEF_W:0] m2_reg, m3_reg, m4_reg, m5_reg, m8_reg;
    // stage b: second-level products
    logic signed [COEF_W:0] p_reg [8];
    logic signed [COEF_W:0] m2b_reg, m3b_reg, m4b_reg, m5b_reg, m8b_reg;
    coef_t m_reg [9];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        sysp_reg <= clamp_c(CW'(fx_mul(sy, sp)));
        cysp_reg <= clamp_c(CW'(fx_mul(cy, sp)));
        sy_a_reg <= sy;
        cy_a_reg <= cy;
        sr_a_reg <= sr;
        cr_a_reg <= cr;
        m2_reg   <= fx_mul(sy, cp);
        m3_reg   <= fx_mul(cp, sr);
        m4_reg   <= fx_mul(cp, cr);
        m5_reg   <= -(COEF_W+1)'(sp);
        m8_reg   <= fx_mul(cy, cp);

        p_reg[0] <= fx_mul(cy_a_reg, cr_a_reg);
        p_reg[1] <= fx_mul(sysp_reg, sr_a_reg);
        p_reg[2] <= fx_mul(sysp_reg, cr_a_reg);
        p_reg[3] <= fx_mul(cy_a_reg, sr_a_reg);
        p_reg[4] <= fx_mul(cysp_reg, sr_a_reg);
        p_reg[5] <= fx_mul(sy_a_reg, cr_a_reg);
        p_reg[6] <= fx_mul(sy_a_reg, sr_a_reg);
        p_reg[7] <= fx_mul(cysp_reg, cr_a_reg);
        m2b_reg  <= m2_reg;
        m3b_reg  <= m3_reg;
        m4b_reg  <= m4_reg;
        m5b_reg  <= m5_reg;
        m8b_reg  <= m8_reg;

        m_reg[0] <= clamp_c(CW'(p_reg[0]) + CW'(p_reg[1]));
        m_reg[1] <= clamp_c(CW'(p_reg[2]) - CW'(p_reg[3]));
        m_reg[2] <= clamp_c(CW'(m2b_reg));
        m_reg[3] <= clamp_c(CW'(m3b_reg));
        m_reg[4] <= clamp_c(CW'(m4b_reg));
        m_reg[5] <= clamp_c(CW'(m5b_reg));
        m_reg[6] <= clamp_c(CW'(p_reg[4]) - CW'(p_reg[5]));
        m_reg[7] <= clamp_c(CW'(p_reg[6]) + CW'(p_reg[7]));
        m_reg[8] <= clamp_c(CW'(m8b_reg));
    end

    assign out_valid = valid_reg[2];
    assign m         = m_reg;

endmodule

// ----- hw/rtl/euler_yxz_world_matrix.sv -----
// ----------------------------------------------------------------------------
// euler_yxz_world_matrix
// yxz euler angles and position to an affine world transform
// ----------------------------------------------------------------------------
// A new beat may be started in every cycle; busy is tied low. Each beat's
// result appears on done for one cycle. The path from start to done is one
// input register, 30 cordic micro-rotation stages, one rounding stage and
// three product and sum stages; the cordic chain is most of it. The
// receiver must take every done beat.
module euler_yxz_world_matrix
    import eyxz_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [15:0]         yaw_angle,
    input  logic signed [15:0]         pitch_angle,
    input  logic signed [15:0]         roll_angle,
    input  logic signed [31:0]         pos_x,
    input  logic signed [31:0]         pos_y,
    input  logic signed [31:0]         pos_z,
    output logic                       done,
    output logic signed [COEF_W-1:0]   m00, m01, m02, m10, m11, m12, m20, m21, m22,
    output logic signed [31:0]         trans_x,
    output logic signed [31:0]         trans_y,
    output logic signed [31:0]         trans_z
);

    localparam int LAT = CORDIC_ITERS + 5;

    logic            in_valid_reg;
    cordic_t         init_reg [3];
    cordic_t         init_next [3];
    logic [CORDIC_ITERS:0] v;
    cordic_t         chain [CORDIC_ITERS+1][3];
    logic            rnd_valid_reg;
    coef_t           s_reg [3];
    coef_t           c_reg [3];
    logic            mat_valid;
    coef_t           m [9];
    logic [95:0]     pos_reg [LAT];
    logic [ANGLE_BITS-1:0] ang [3];

    assign busy   = 1'b0;
    assign ang[0] = ANGLE_BITS'(yaw_angle);
    assign ang[1] = ANGLE_BITS'(pitch_angle);
    assign ang[2] = ANGLE_BITS'(roll_angle);

    // phase fold: quadrants 1 and 2 turn by half a turn
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic [31:0] ph;
            ph = {ang[k], (32-ANGLE_BITS)'(0)};
            init_next[k].flip = ph[31] ^ ph[30];
            if (ph[31] ^ ph[30])
                ph = ph + 32'h80000000;
            init_next[k].x = CORDIC_GAIN;
            init_next[k].y = '0;
            init_next[k].z = CW'($signed(ph));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            rnd_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= start;
            rnd_valid_reg <= v[CORDIC_ITERS];
        end
    end

    always_ff @(posedge clk)
    begin
        init_reg <= init_next;
    end

    assign v[0]     = in_valid_reg;
    assign chain[0] = init_reg;

    for (genvar i = 0; i < CORDIC_ITERS; i++)
    begin : g_cordic
        eyxz_cordic_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .iter      (5'(i)),
            .in_valid  (v[i]),
            .in_ang    (chain[i]),
            .out_valid (v[i+1]),
            .out_ang   (chain[i+1])
        );
    end

    // round q3.30 to q1.f and clamp, negating folded angles
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic signed [CW-1:0] xs, ys;
            xs = chain[CORDIC_ITERS][k].flip ? -chain[CORDIC_ITERS][k].x
                                             : chain[CORDIC_ITERS][k].x;
            ys = chain[CORDIC_ITERS][k].flip ? -chain[CORDIC_ITERS][k].y
                                             : chain[CORDIC_ITERS][k].y;
            if (RND_SH == 0)
            begin
                s_reg[k] <= clamp_c(ys);
                c_reg[k] <= clamp_c(xs);
            end
            else
            begin
                s_reg[k] <= clamp_c((ys + (CW'(1) <<< (RND_SH-1))) >>> RND_SH);
                c_reg[k] <= clamp_c((xs + (CW'(1) <<< (RND_SH-1))) >>> RND_SH);
            end
        end
    end

    eyxz_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rnd_valid_reg),
        .sy        (s_reg[0]),
        .cy        (c_reg[0]),
        .sp        (s_reg[1]),
        .cp        (c_reg[1]),
        .sr        (s_reg[2]),
        .cr        (c_reg[2]),
        .out_valid (mat_valid),
        .m         (m)
    );

    // translation rides alongside the rotation path
    always_ff @(posedge clk)
    begin
        pos_reg[0] <= {pos_x, pos_y, pos_z};
        for (int k = 1; k < LAT; k++)
            pos_reg[k] <= pos_reg[k-1];
    end

    assign done    = mat_valid;
    assign m00     = m[0];
    assign m01     = m[1];
    assign m02     = m[2];
    assign m10     = m[3];
    assign m11     = m[4];
    assign m12     = m[5];
    assign m20     = m[6];
    assign m21     = m[7];
    assign m22     = m[8];
    assign trans_x = pos_reg[LAT-1][95:64];
    assign trans_y = pos_reg[LAT-1][63:32];
    assign trans_z = pos_reg[LAT-1][31:0];

    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        $past(start, LAT) |-> done) else $error("lost beat");
    a_nospur: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(rnd_valid_reg, 3)) else $error("spurious beat");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (m12 <= ONE_C && m12 >= MONE_C)) else $error("entry range");
    a_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        v[CORDIC_ITERS] |-> $past(in_valid_reg, CORDIC_ITERS)) else $error("chain valid");

endmodule

// ----- test/tb_euler_yxz_world_matrix.sv -----
// ----------------------------------------------------------------------------
// tb_euler_yxz_world_matrix
// self-checking bench for the yxz euler world matrix: a bit-true cordic and
// product predictor, a queue-fed start driver and a done-strobe monitor
// ----------------------------------------------------------------------------
module tb_euler_yxz_world_matrix;
    import eyxz_pkg::*;

    typedef struct {
        logic [15:0] yaw;
        logic [15:0] pitch;
        logic [15:0] roll;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
    } pose_t;

    typedef struct {
        logic [COEF_W-1:0] m [9];
        logic [31:0]       tx;
        logic [31:0]       ty;
        logic [31:0]       tz;
    } xform_t;

    localparam longint UNIT = longint'(1) << COEF_FRAC_BITS;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [15:0] yaw_angle = '0, pitch_angle = '0, roll_angle = '0;
    logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic done;
    logic signed [COEF_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [31:0] trans_x, trans_y, trans_z;

    pose_t  pose_q [$];
    xform_t xform_q [$];
    int     errors = 0;
    int     beats_in = 0;
    int     beats_out = 0;
    longint cycles = 0;
    bit     quiet = 1'b0;

    euler_yxz_world_matrix dut (.*);

    always #1 clk = ~clk;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp_one(longint v);
        if (v > UNIT)
            return UNIT;
        if (v < -UNIT)
            return -UNIT;
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return floor_shift(a * b + (longint'(1) << (COEF_FRAC_BITS - 1)), COEF_FRAC_BITS);
    endfunction

    function automatic longint arctan_step(int i);
        longint t [30] = '{
            'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
            'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
            'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
            'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
            'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001};
        return t[i];
    endfunction

    function automatic void sincos(logic [15:0] a, output longint s, output longint c);
        logic [31:0] phase;
        bit flip;
        longint x, y, z, dx, dy;
        phase = {a[ANGLE_BITS-1:0], {(32 - ANGLE_BITS){1'b0}}};
        flip = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
        if (flip)
            phase = phase + 32'h80000000;
        x = 652032874;
        y = 0;
        z = longint'(signed'(phase));
        for (int i = 0; i < 30; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= arctan_step(i);
            end
            else
            begin
                x += dx; y -= dy; z += arctan_step(i);
            end
        end
        if (flip)
        begin
            x = -x; y = -y;
        end
        if (RND_SH == 0)
        begin
            s = clamp_one(y); c = clamp_one(x);
        end
        else
        begin
            s = clamp_one(floor_shift(y + (longint'(1) << (RND_SH - 1)), RND_SH));
            c = clamp_one(floor_shift(x + (longint'(1) << (RND_SH - 1)), RND_SH));
        end
    endfunction

    function automatic xform_t world_matrix(pose_t p);
        xform_t r;
        longint sy, cy, sp, cp, sr, cr, sysp, cysp;
        longint e [9];
        sincos(p.yaw, sy, cy);
        sincos(p.pitch, sp, cp);
        sincos(p.roll, sr, cr);
        sysp = qmul(sy, sp);
        cysp = qmul(cy, sp);
        e[0] = qmul(cy, cr) + qmul(sysp, sr);
        e[1] = qmul(sysp, cr) - qmul(cy, sr);
        e[2] = qmul(sy, cp);
        e[3] = qmul(cp, sr);
        e[4] = qmul(cp, cr);
        e[5] = -sp;
        e[6] = qmul(cysp, sr) - qmul(sy, cr);
        e[7] = qmul(sy, sr) + qmul(cysp, cr);
        e[8] = qmul(cy, cp);
        for (int k = 0; k < 9; k++)
            r.m[k] = COEF_W'(clamp_one(e[k]));
        r.tx = p.px; r.ty = p.py; r.tz = p.pz;
        return r;
    endfunction

    function automatic pose_t mk_pose(logic [15:0] y, logic [15:0] p, logic [15:0] r,
                                      logic [31:0] x, logic [31:0] yy, logic [31:0] z);
        pose_t q;
        q.yaw = y; q.pitch = p; q.roll = r; q.px = x; q.py = yy; q.pz = z;
        return q;
    endfunction

    function automatic logic [15:0] rand_angle();
        logic [15:0] special [8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                     16'h3FFF, 16'h7FFF, 16'hFFFF, 16'h0001};
        if ($urandom_range(0, 9) == 0)
            return special[$urandom_range(0, 7)];
        return 16'($urandom);
    endfunction

    initial
    begin
        logic [15:0] corner [8];
        corner = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                   16'h7FFF, 16'h8001, 16'h3FFF, 16'hBFFF};
        for (int i = 0; i < 8; i++)
            pose_q.push_back(mk_pose(corner[i], corner[(i + 3) % 8], corner[(i + 5) % 8],
                                     32'h7FFFFFFF, 32'h80000000, 32'h0));
        pose_q.push_back(mk_pose(16'h2000, 16'h2000, 16'h2000,
                                 32'hFFFFFFFF, 32'h0, 32'h00010000));
        pose_q.push_back(mk_pose(16'hE000, 16'h6000, 16'hA000,
                                 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF));
        for (int i = 0; i < 1550; i++)
            pose_q.push_back(mk_pose(rand_angle(), rand_angle(), rand_angle(),
                                     $urandom, $urandom, $urandom));
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // driver: new beat offered at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                beats_in <= beats_in + 1;
            quiet <= (cycles > 600 && cycles < 1400);
            if (start && busy)
                ;
            else if (pose_q.size() > 0 && (quiet || $urandom_range(0, 99) >= 6))
            begin
                pose_t p;
                p = pose_q.pop_front();
                xform_q.push_back(world_matrix(p));
                yaw_angle <= p.yaw; pitch_angle <= p.pitch; roll_angle <= p.roll;
                pos_x <= p.px; pos_y <= p.py; pos_z <= p.pz;
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: done beats sampled at the rising edge
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && done)
        begin
            logic [COEF_W-1:0] got [9];
            xform_t want;
            got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
            beats_out <= beats_out + 1;
            if (xform_q.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
            end
            else
            begin
                want = xform_q.pop_front();
                for (int k = 0; k < 9; k++)
                    if (got[k] !== want.m[k])
                    begin
                        $error("m%0d%0d: expected %0d actual %0d", k / 3, k % 3,
                               $signed(want.m[k]), $signed(got[k]));
                        errors++;
                    end
                if (trans_x !== want.tx)
                begin
                    $error("trans_x: expected %h actual %h", want.tx, trans_x);
                    errors++;
                end
                if (trans_y !== want.ty)
                begin
                    $error("trans_y: expected %h actual %h", want.ty, trans_y);
                    errors++;
                end
                if (trans_z !== want.tz)
                begin
                    $error("trans_z: expected %h actual %h", want.tz, trans_z);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        wait (rst_n);
        while ((pose_q.size() > 0 || start || xform_q.size() > 0) && cycles < CYCLE_LIMIT)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("euler_yxz_world_matrix: mismatch");
            $finish;
        end
        else
        begin
            $display("sent %0d poses (angle corners, quadrant edges, random), checked %0d",
                     beats_in, beats_out);
            if (errors == 0 && xform_q.size() == 0)
                $display("euler_yxz_world_matrix: match");
            else
                $display("euler_yxz_world_matrix: mismatch");
            $finish;
        end
    end

endmodule
